FILE: src/hsvd_pkg.sv
// ----------------------------------------------------------------------------
// hsvd_pkg
// shared types, register indexes and fixed-point helpers for the hsv to rgb
// converter with dimming
// ----------------------------------------------------------------------------
`default_nettype none

package hsvd_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;
    localparam logic [1:0] CFG_POWER_ON   = 2'd2;

    // color mode codes
    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_RGB = 1'b1;

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned SECTORS    = 6;

    localparam logic [7:0]  FULL_SCALE_B = 8'(FULL_SCALE);
    localparam logic [15:0] FULL_SQ      = 16'(FULL_SCALE * FULL_SCALE);
    localparam logic [2:0]  LAST_SECTOR  = 3'(SECTORS - 1);

    // reciprocal of 255, exact for any 16-bit dividend with a shift of 23
    localparam logic [16:0] RECIP_255 = 17'd32897;
    // reciprocal of 65025 with a shift of 32, low by at most one
    localparam logic [16:0] RECIP_SQ  = 17'd66051;

    localparam logic [7:0]  BRIGHT_RESET = 8'd255;
    localparam logic [15:0] ROUND_HALF   = 16'd127;

    typedef struct packed {
        logic       color_mode;
        logic [7:0] brightness;
        logic       power_on;
    } t_cfg;

    // floor(x / 255) for x up to 65279 (result fits a byte)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] prod;
        prod = {17'b0, x} * {16'b0, RECIP_255};
        return prod[30:23];
    endfunction

endpackage

`default_nettype wire

FILE: src/hsvd_in_if.sv
// ----------------------------------------------------------------------------
// hsvd_in_if
// input channel: three color bytes with valid / ready
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

`default_nettype wire

FILE: src/hsvd_out_if.sv
// ----------------------------------------------------------------------------
// hsvd_out_if
// rgb channel: red, green and blue bytes with valid / ready
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: src/hsv_to_rgb_with_dimming_top.sv
// pipeline: seven register stages (five convert, two dim) lie between an item
//   accepted at the input and its result at the output
// throughput: one item per cycle; every stage moves whenever the one after it
//   is empty or moving, so a stall at the output fills bubbles before blocking
// reset: synchronous active-low; clears all valid bits and loads hsv mode,
//   brightness 255 and power on
// ----------------------------------------------------------------------------
// hsv_to_rgb_with_dimming_top
// hsv to rgb converter with global dimming and power gating
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_with_dimming_top
    import hsvd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,

    // configuration write port
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_idx,
    input  wire  [7:0]   i_cfg_data,

    // pixel channels
    hsvd_in_if.sink      i_pix,
    hsvd_out_if.source   o_pix
);

    // configuration registers
    t_cfg r_cfg;

    // converted, not yet dimmed items between the two pipelines
    hsvd_out_if conv_pix ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode <= MODE_HSV;
            r_cfg.brightness <= BRIGHT_RESET;
            r_cfg.power_on   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLOR_MODE: r_cfg.color_mode <= i_cfg_data[0];
                CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data;
                CFG_POWER_ON:   r_cfg.power_on   <= i_cfg_data[0];
                default:        ; // writes past the last register are dropped
            endcase
        end
    end

    // sector / fraction, products, divide by 65025, select
    hsvd_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_color_mode (r_cfg.color_mode),
        .i_pix        (i_pix),
        .o_pix        (conv_pix.source)
    );

    // brightness scale and power gate, output register at the end
    hsvd_dim u_dim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (conv_pix.sink),
        .o_pix   (o_pix)
    );

endmodule

`default_nettype wire

FILE: src/hsvd_convert.sv
// ----------------------------------------------------------------------------
// hsvd_convert
// five-stage hsv to rgb conversion pipeline, rgb bytes bypass in rgb mode
// ----------------------------------------------------------------------------
`default_nettype none

module hsvd_convert
    import hsvd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_color_mode,
    hsvd_in_if.sink      i_pix,
    hsvd_out_if.source   o_pix
);

    logic ld1, ld2, ld3, ld4, ld5;
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    // stage 1: sector and fraction
    logic        r_mode1;
    logic [2:0]  r_sec1;
    logic [7:0]  r_fr1, r_ca1, r_cb1, r_cc1;
    logic [10:0] n_h6, n_base;
    logic [2:0]  n_raw, n_sec;
    logic [7:0]  n_fr;

    // stage 2: first products
    logic        r_mode2;
    logic [2:0]  r_sec2;
    logic [7:0]  r_ca2, r_cb2, r_cc2;
    logic [15:0] r_pv2, r_qa2, r_ta2;
    logic [15:0] n_pv, n_fs, n_ts;

    // stage 3: p and the value products
    logic        r_mode3;
    logic [2:0]  r_sec3;
    logic [7:0]  r_ca3, r_cb3, r_cc3, r_p3;
    logic [23:0] r_qx3, r_tx3;

    // stage 4: reciprocal estimate of the divide by 65025
    logic        r_mode4;
    logic [2:0]  r_sec4;
    logic [7:0]  r_ca4, r_cb4, r_cc4, r_p4, r_qe4, r_te4;
    logic [23:0] r_qx4, r_tx4;
    logic [40:0] n_qm, n_tm;

    // stage 5: correction and sector select
    logic [7:0]  r_r5, r_g5, r_b5;
    logic [24:0] n_qrem, n_trem;
    logic [7:0]  n_q, n_t, n_r, n_g, n_b;

    // ready ripples back through each stage that is empty or moving
    always_comb begin
        ld5 = !r_vld5 || o_pix.ready;
        ld4 = !r_vld4 || ld5;
        ld3 = !r_vld3 || ld4;
        ld2 = !r_vld2 || ld3;
        ld1 = !r_vld1 || ld2;
    end

    assign i_pix.ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (ld1) r_vld1 <= i_pix.valid;
            if (ld2) r_vld2 <= r_vld1;
            if (ld3) r_vld3 <= r_vld2;
            if (ld4) r_vld4 <= r_vld3;
            if (ld5) r_vld5 <= r_vld4;
        end
    end

    // h*6 split into sector and fraction; hue 255 wraps to sector 0, fraction 0
    always_comb begin
        n_h6 = {1'b0, i_pix.chan_a, 2'b00} + {2'b00, i_pix.chan_a, 1'b0};
        if (n_h6 < 11'd255) begin
            n_raw = 3'd0; n_base = 11'd0;
        end else if (n_h6 < 11'd510) begin
            n_raw = 3'd1; n_base = 11'd255;
        end else if (n_h6 < 11'd765) begin
            n_raw = 3'd2; n_base = 11'd510;
        end else if (n_h6 < 11'd1020) begin
            n_raw = 3'd3; n_base = 11'd765;
        end else if (n_h6 < 11'd1275) begin
            n_raw = 3'd4; n_base = 11'd1020;
        end else if (n_h6 < 11'd1530) begin
            n_raw = 3'd5; n_base = 11'd1275;
        end else begin
            n_raw = 3'd6; n_base = 11'd1530;
        end
        n_fr  = 8'(n_h6 - n_base);
        n_sec = (n_raw > LAST_SECTOR) ? 3'd0 : n_raw;
    end

    always_comb begin
        n_pv = {8'b0, r_cc1} * {8'b0, FULL_SCALE_B - r_cb1};
        n_fs = {8'b0, r_fr1} * {8'b0, r_cb1};
        n_ts = {8'b0, FULL_SCALE_B - r_fr1} * {8'b0, r_cb1};
    end

    always_comb begin
        n_qm = {17'b0, r_qx3} * {24'b0, RECIP_SQ};
        n_tm = {17'b0, r_tx3} * {24'b0, RECIP_SQ};
    end

    // estimate is low by at most one: one compare on the remainder fixes it
    always_comb begin
        n_qrem = {1'b0, r_qx4} - {1'b0, 24'({16'b0, r_qe4} * {8'b0, FULL_SQ})};
        n_trem = {1'b0, r_tx4} - {1'b0, 24'({16'b0, r_te4} * {8'b0, FULL_SQ})};
        n_q = (n_qrem >= {9'b0, FULL_SQ}) ? r_qe4 + 8'd1 : r_qe4;
        n_t = (n_trem >= {9'b0, FULL_SQ}) ? r_te4 + 8'd1 : r_te4;

        case (r_sec4)
            3'd0:    begin n_r = r_cc4; n_g = n_t;   n_b = r_p4;  end
            3'd1:    begin n_r = n_q;   n_g = r_cc4; n_b = r_p4;  end
            3'd2:    begin n_r = r_p4;  n_g = r_cc4; n_b = n_t;   end
            3'd3:    begin n_r = r_p4;  n_g = n_q;   n_b = r_cc4; end
            3'd4:    begin n_r = n_t;   n_g = r_p4;  n_b = r_cc4; end
            default: begin n_r = r_cc4; n_g = r_p4;  n_b = n_q;   end
        endcase

        if (r_mode4 == MODE_RGB) begin
            n_r = r_ca4;
            n_g = r_cb4;
            n_b = r_cc4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_mode1 <= i_color_mode;
            r_sec1  <= n_sec;
            r_fr1   <= n_fr;
            r_ca1   <= i_pix.chan_a;
            r_cb1   <= i_pix.chan_b;
            r_cc1   <= i_pix.chan_c;
        end
        if (ld2) begin
            r_mode2 <= r_mode1;
            r_sec2  <= r_sec1;
            r_ca2   <= r_ca1;
            r_cb2   <= r_cb1;
            r_cc2   <= r_cc1;
            r_pv2   <= n_pv;
            r_qa2   <= FULL_SQ - n_fs;
            r_ta2   <= FULL_SQ - n_ts;
        end
        if (ld3) begin
            r_mode3 <= r_mode2;
            r_sec3  <= r_sec2;
            r_ca3   <= r_ca2;
            r_cb3   <= r_cb2;
            r_cc3   <= r_cc2;
            r_p3    <= div255(r_pv2);
            r_qx3   <= {8'b0, r_cc2} * {8'b0, r_qa2};
            r_tx3   <= {8'b0, r_cc2} * {8'b0, r_ta2};
        end
        if (ld4) begin
            r_mode4 <= r_mode3;
            r_sec4  <= r_sec3;
            r_ca4   <= r_ca3;
            r_cb4   <= r_cb3;
            r_cc4   <= r_cc3;
            r_p4    <= r_p3;
            r_qx4   <= r_qx3;
            r_tx4   <= r_tx3;
            r_qe4   <= n_qm[39:32];
            r_te4   <= n_tm[39:32];
        end
        if (ld5) begin
            r_r5 <= n_r;
            r_g5 <= n_g;
            r_b5 <= n_b;
        end
    end

    assign o_pix.valid = r_vld5;
    assign o_pix.red   = r_r5;
    assign o_pix.green = r_g5;
    assign o_pix.blue  = r_b5;

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> r_sec1 <= LAST_SECTOR)
        else $error("sector out of range");

    a_p_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> r_p4 <= r_cc4)
        else $error("p exceeds value");

    a_estimate_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (r_qe4 <= r_cc4 && r_te4 <= r_cc4))
        else $error("quotient estimate exceeds value");

endmodule

`default_nettype wire

FILE: src/hsvd_dim.sv
// ----------------------------------------------------------------------------
// hsvd_dim
// two-stage brightness scaling with round half up and power gating
// ----------------------------------------------------------------------------
`default_nettype none

module hsvd_dim
    import hsvd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cfg    i_cfg,
    hsvd_out_if.sink     i_pix,
    hsvd_out_if.source   o_pix
);

    logic ld6, ld7;
    logic r_vld6, r_vld7;
    logic [15:0] r_mr6, r_mg6, r_mb6;
    logic [7:0]  r_r7, r_g7, r_b7;

    always_comb begin
        ld7 = !r_vld7 || o_pix.ready;
        ld6 = !r_vld6 || ld7;
    end

    assign i_pix.ready = ld6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else begin
            if (ld6) r_vld6 <= i_pix.valid;
            if (ld7) r_vld7 <= r_vld6;
        end
    end

    // c*b/255 rounded half up equals floor((c*b + 127) / 255)
    always_ff @(posedge i_clk) begin
        if (ld6) begin
            r_mr6 <= {8'b0, i_pix.red}   * {8'b0, i_cfg.brightness} + ROUND_HALF;
            r_mg6 <= {8'b0, i_pix.green} * {8'b0, i_cfg.brightness} + ROUND_HALF;
            r_mb6 <= {8'b0, i_pix.blue}  * {8'b0, i_cfg.brightness} + ROUND_HALF;
        end
        if (ld7) begin
            r_r7 <= i_cfg.power_on ? div255(r_mr6) : 8'd0;
            r_g7 <= i_cfg.power_on ? div255(r_mg6) : 8'd0;
            r_b7 <= i_cfg.power_on ? div255(r_mb6) : 8'd0;
        end
    end

    assign o_pix.valid = r_vld7;
    assign o_pix.red   = r_r7;
    assign o_pix.green = r_g7;
    assign o_pix.blue  = r_b7;

endmodule

`default_nettype wire
